// ===== design/vtolmix_pkg.sv =====
`timescale 1ns / 1ps

package vtolmix_pkg;

	// Channel and field widths.
	localparam int CHAN_W     = 12;
	localparam int LEVEL_W    = 7;
	localparam int GAIN_W     = 16;
	localparam int CFG_ADDR_W = 5;
	localparam int CFG_DATA_W = 32;

	// Transition range and channel limits.
	localparam int MIN_TRANSITION  = 0;
	localparam int MAX_TRANSITION  = 90;
	localparam int HALF_TRANSITION = MAX_TRANSITION / 2;
	localparam int OUTPUT_MIN      = -2048;
	localparam int OUTPUT_MAX      = 2047;
	localparam int INPUT_MIN       = -2048;
	localparam int INPUT_CENTRE    = 0;

	// Register reset values.
	localparam int THR_LOW_RESET     = -683;
	localparam int THR_HIGH_RESET    = 683;
	localparam int DEAD_MARGIN_RESET = 100;
	localparam int HORZ_GAIN_RESET   = 4096;
	localparam int VERT_GAIN_RESET   = 4096;

	typedef logic signed [CHAN_W-1:0] chan_t;
	typedef logic [LEVEL_W-1:0] level_t;

	typedef enum logic [1:0] {
		CM_ANGLE  = 2'd0,
		CM_RATE   = 2'd1,
		CM_MANUAL = 2'd2
	} cmode_t;

	typedef enum logic [1:0] {
		FM_DISABLED   = 2'd0,
		FM_VERTICAL   = 2'd1,
		FM_HORIZONTAL = 2'd2
	} fmode_t;

	typedef enum logic [2:0] {
		REG_THR_LOW     = 3'd0,
		REG_THR_HIGH    = 3'd1,
		REG_DEAD_MARGIN = 3'd2,
		REG_HORZ_GAIN   = 3'd3,
		REG_VERT_GAIN   = 3'd4
	} reg_idx_t;

	typedef struct packed {
		chan_t             thr_low;
		chan_t             thr_high;
		logic [CHAN_W-1:0] dead_margin;
		logic [GAIN_W-1:0] horz_gain;
		logic [GAIN_W-1:0] vert_gain;
	} cfg_t;

	typedef struct packed {
		cmode_t cmode;
		fmode_t fmode;
		logic   force_idle;
	} mode_dec_t;

	// Saturate a widened sum to the channel range.
	function automatic chan_t sat_chan(input logic signed [17:0] v);
		logic signed [17:0] lo;
		logic signed [17:0] hi;
		lo = 18'(OUTPUT_MIN);
		hi = 18'(OUTPUT_MAX);
		priority if (v < lo) begin
			return chan_t'(lo);
		end else if (v > hi) begin
			return chan_t'(hi);
		end else begin
			return chan_t'(v);
		end
	endfunction

endpackage

// ===== design/vtolmix_cfg.sv =====
`timescale 1ns / 1ps

module vtolmix_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [vtolmix_pkg::CFG_ADDR_W-1:0]  paddr,
	input  logic [vtolmix_pkg::CFG_DATA_W-1:0]  pwdata,
	output logic [vtolmix_pkg::CFG_DATA_W-1:0]  prdata,
	output logic                                pready,
	output vtolmix_pkg::cfg_t                   cfg
);

	vtolmix_pkg::cfg_t cfg_q;
	logic [2:0]        idx;
	logic              wr_en;

	assign idx    = paddr[4:2];
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.thr_low     <= vtolmix_pkg::chan_t'(vtolmix_pkg::THR_LOW_RESET);
			cfg_q.thr_high    <= vtolmix_pkg::chan_t'(vtolmix_pkg::THR_HIGH_RESET);
			cfg_q.dead_margin <= vtolmix_pkg::CHAN_W'(vtolmix_pkg::DEAD_MARGIN_RESET);
			cfg_q.horz_gain   <= vtolmix_pkg::GAIN_W'(vtolmix_pkg::HORZ_GAIN_RESET);
			cfg_q.vert_gain   <= vtolmix_pkg::GAIN_W'(vtolmix_pkg::VERT_GAIN_RESET);
		end else if (wr_en) begin
			unique case (vtolmix_pkg::reg_idx_t'(idx))
				vtolmix_pkg::REG_THR_LOW:     cfg_q.thr_low     <= pwdata[11:0];
				vtolmix_pkg::REG_THR_HIGH:    cfg_q.thr_high    <= pwdata[11:0];
				vtolmix_pkg::REG_DEAD_MARGIN: cfg_q.dead_margin <= pwdata[11:0];
				vtolmix_pkg::REG_HORZ_GAIN:   cfg_q.horz_gain   <= pwdata[15:0];
				vtolmix_pkg::REG_VERT_GAIN:   cfg_q.vert_gain   <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (vtolmix_pkg::reg_idx_t'(idx))
			vtolmix_pkg::REG_THR_LOW:     prdata = {20'd0, cfg_q.thr_low};
			vtolmix_pkg::REG_THR_HIGH:    prdata = {20'd0, cfg_q.thr_high};
			vtolmix_pkg::REG_DEAD_MARGIN: prdata = {20'd0, cfg_q.dead_margin};
			vtolmix_pkg::REG_HORZ_GAIN:   prdata = {16'd0, cfg_q.horz_gain};
			vtolmix_pkg::REG_VERT_GAIN:   prdata = {16'd0, cfg_q.vert_gain};
			default:                      prdata = '0;
		endcase
	end

endmodule

// ===== design/vtolmix_mode.sv =====
`timescale 1ns / 1ps

module vtolmix_mode (
	input  vtolmix_pkg::cfg_t      cfg,
	input  vtolmix_pkg::chan_t     throttle_stick,
	input  vtolmix_pkg::chan_t     aileron_stick,
	input  vtolmix_pkg::chan_t     elevator_stick,
	input  vtolmix_pkg::chan_t     rudder_stick,
	input  vtolmix_pkg::chan_t     control_switch,
	input  vtolmix_pkg::chan_t     gear_switch,
	input  logic                   rx_failed,
	input  logic                   imu_failed,
	input  vtolmix_pkg::chan_t     roll_cmd,
	input  vtolmix_pkg::chan_t     pitch_cmd,
	input  vtolmix_pkg::chan_t     yaw_cmd,
	output vtolmix_pkg::mode_dec_t mode,
	output vtolmix_pkg::chan_t     thro,
	output vtolmix_pkg::chan_t     roll,
	output vtolmix_pkg::chan_t     pitch,
	output vtolmix_pkg::chan_t     yaw
);

	vtolmix_pkg::chan_t aile;
	vtolmix_pkg::chan_t elev;
	vtolmix_pkg::chan_t rudd;

	always_comb begin
		mode.cmode = vtolmix_pkg::CM_ANGLE;
		if (control_switch < cfg.thr_high) mode.cmode = vtolmix_pkg::CM_RATE;
		if (control_switch < cfg.thr_low)  mode.cmode = vtolmix_pkg::CM_MANUAL;
		if (rx_failed)                     mode.cmode = vtolmix_pkg::CM_ANGLE;
		if (imu_failed)                    mode.cmode = vtolmix_pkg::CM_MANUAL;

		mode.fmode = vtolmix_pkg::FM_DISABLED;
		if (gear_switch < cfg.thr_high) mode.fmode = vtolmix_pkg::FM_VERTICAL;
		if (gear_switch < cfg.thr_low)  mode.fmode = vtolmix_pkg::FM_HORIZONTAL;
		priority if (rx_failed && imu_failed) begin
			mode.fmode = vtolmix_pkg::FM_DISABLED;
		end else if (rx_failed || imu_failed) begin
			mode.fmode = vtolmix_pkg::FM_HORIZONTAL;
		end else begin
		end

		mode.force_idle = (mode.fmode == vtolmix_pkg::FM_DISABLED) || rx_failed;
	end

	// Idle throttle and centred sticks while disabled or without a link.
	always_comb begin
		if (mode.force_idle) begin
			thro = vtolmix_pkg::chan_t'(vtolmix_pkg::INPUT_MIN);
			aile = vtolmix_pkg::chan_t'(vtolmix_pkg::INPUT_CENTRE);
			elev = vtolmix_pkg::chan_t'(vtolmix_pkg::INPUT_CENTRE);
			rudd = vtolmix_pkg::chan_t'(vtolmix_pkg::INPUT_CENTRE);
		end else begin
			thro = throttle_stick;
			aile = aileron_stick;
			elev = elevator_stick;
			rudd = rudder_stick;
		end
	end

	always_comb begin
		if (mode.cmode == vtolmix_pkg::CM_MANUAL) begin
			roll  = aile;
			pitch = elev;
			yaw   = rudd;
		end else begin
			roll  = roll_cmd;
			pitch = pitch_cmd;
			yaw   = yaw_cmd;
		end
	end

endmodule

// ===== design/vtolmix_trans.sv =====
`timescale 1ns / 1ps

module vtolmix_trans (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  vtolmix_pkg::fmode_t fmode,
	output vtolmix_pkg::level_t level,
	output logic                horz,
	output vtolmix_pkg::chan_t  gear
);

	localparam int LutDepth = 1 << vtolmix_pkg::LEVEL_W;
	localparam int Half     = vtolmix_pkg::HALF_TRANSITION;
	localparam int Span     = vtolmix_pkg::MAX_TRANSITION - Half;
	localparam int OutRange = vtolmix_pkg::OUTPUT_MAX - vtolmix_pkg::OUTPUT_MIN;

	localparam vtolmix_pkg::level_t LvlMin = vtolmix_pkg::LEVEL_W'(vtolmix_pkg::MIN_TRANSITION);
	localparam vtolmix_pkg::level_t LvlMax = vtolmix_pkg::LEVEL_W'(vtolmix_pkg::MAX_TRANSITION);
	localparam vtolmix_pkg::level_t LvlHalf = vtolmix_pkg::LEVEL_W'(Half);

	vtolmix_pkg::level_t level_q;
	logic                seen_q;
	vtolmix_pkg::chan_t  gear_lut [0:LutDepth-1];

	always_comb begin
		priority if (!seen_q) begin
			level = (fmode == vtolmix_pkg::FM_HORIZONTAL) ? LvlMin : LvlMax;
		end else if (fmode == vtolmix_pkg::FM_HORIZONTAL) begin
			level = (level_q <= LvlMin) ? LvlMin : level_q - 1'b1;
		end else begin
			level = (level_q >= LvlMax) ? LvlMax : level_q + 1'b1;
		end
	end

	assign horz = level < LvlHalf;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
			seen_q  <= 1'b0;
		end else if (advance) begin
			level_q <= level;
			seen_q  <= 1'b1;
		end
	end

	// Servo position for each level, worked out at elaboration.
	for (genvar gi = 0; gi < LutDepth; gi++) begin : g_gear
		localparam int Raw = (gi < Half || gi > vtolmix_pkg::MAX_TRANSITION) ?
			vtolmix_pkg::OUTPUT_MIN :
			vtolmix_pkg::OUTPUT_MIN + ((gi - Half) * OutRange) / Span;
		localparam int Sat = (Raw > vtolmix_pkg::OUTPUT_MAX) ? vtolmix_pkg::OUTPUT_MAX : Raw;
		assign gear_lut[gi] = vtolmix_pkg::chan_t'(Sat);
	end

	assign gear = gear_lut[level];

endmodule

// ===== design/vtolmix_mixer.sv =====
`timescale 1ns / 1ps

module vtolmix_mixer (
	input  vtolmix_pkg::cfg_t  cfg,
	input  logic               horz,
	input  vtolmix_pkg::chan_t thro,
	input  vtolmix_pkg::chan_t roll,
	input  vtolmix_pkg::chan_t pitch,
	input  vtolmix_pkg::chan_t yaw,
	output vtolmix_pkg::chan_t starboard_elevon,
	output vtolmix_pkg::chan_t portside_elevon,
	output vtolmix_pkg::chan_t starboard_thrust,
	output vtolmix_pkg::chan_t portside_thrust
);

	logic signed [28:0] yaw_prod;
	logic signed [28:0] roll_prod;
	logic signed [16:0] diff;
	logic signed [17:0] thro_w;
	logic signed [17:0] diff_w;
	logic signed [17:0] pitch_w;
	logic signed [17:0] roll_w;
	logic signed [17:0] yaw_w;
	logic signed [17:0] re_w;
	logic signed [17:0] le_w;
	logic signed [13:0] dead_lim;
	logic               dead;

	// Both differential products run side by side; the level picks one.
	assign yaw_prod  = $signed({{17{yaw[11]}}, yaw}) * $signed({13'd0, cfg.horz_gain});
	assign roll_prod = $signed({{17{roll[11]}}, roll}) * $signed({13'd0, cfg.vert_gain});

	// Dropping the twelve fraction bits floors the product with the Q4.12 gain.
	assign diff = horz ? yaw_prod[28:12] : roll_prod[28:12];

	assign thro_w  = 18'(thro);
	assign diff_w  = 18'(diff);
	assign pitch_w = 18'(pitch);
	assign roll_w  = 18'(roll);
	assign yaw_w   = 18'(yaw);

	assign re_w = horz ? pitch_w + roll_w : pitch_w - yaw_w;
	assign le_w = horz ? pitch_w - roll_w : pitch_w + yaw_w;

	assign dead_lim = 14'(vtolmix_pkg::OUTPUT_MIN) + $signed({2'b00, cfg.dead_margin});
	assign dead     = 14'(thro) < dead_lim;

	assign starboard_elevon = vtolmix_pkg::sat_chan(re_w);
	assign portside_elevon  = vtolmix_pkg::sat_chan(le_w);

	always_comb begin
		if (dead) begin
			starboard_thrust = vtolmix_pkg::chan_t'(vtolmix_pkg::OUTPUT_MIN);
			portside_thrust  = vtolmix_pkg::chan_t'(vtolmix_pkg::OUTPUT_MIN);
		end else begin
			starboard_thrust = vtolmix_pkg::sat_chan(thro_w - diff_w);
			portside_thrust  = vtolmix_pkg::sat_chan(thro_w + diff_w);
		end
	end

endmodule

// ===== design/vtol_mode_transition_mixer_unit.sv =====
`timescale 1ns / 1ps

// Channel      Direction  Handshake            Contents
// request in   input      in_valid / in_stall  sticks, switches, failure flags, axis commands
// result out   output     out_valid/out_stall  elevons, motors, gear servo, level, modes
// config       input      APB (psel/penable)   thresholds, dead-stick margin, mix gains
//
// A request lands in the input register at its accepting edge, and once the result register
// is empty or being taken it passes through the mode, transition and mix logic into the
// result register. A new request is accepted every cycle unless in_stall is raised.
// The transition level and the first-tick flag update as a request enters the result
// register. Reset clears the valid flags, the transition level and the first-tick flag,
// and loads the register reset values. A stalled result holds the result register; the
// input register holds its request and raises in_stall only when both registers are
// occupied and the result is stalled.

module vtol_mode_transition_mixer_unit (
	input  logic                               clk,
	input  logic                               arst_n,

	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic signed [11:0]                 throttle_stick,
	input  logic signed [11:0]                 aileron_stick,
	input  logic signed [11:0]                 elevator_stick,
	input  logic signed [11:0]                 rudder_stick,
	input  logic signed [11:0]                 control_switch,
	input  logic signed [11:0]                 gear_switch,
	input  logic                               rx_failed,
	input  logic                               imu_failed,
	input  logic signed [11:0]                 roll_cmd,
	input  logic signed [11:0]                 pitch_cmd,
	input  logic signed [11:0]                 yaw_cmd,

	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [11:0]                 starboard_elevon,
	output logic signed [11:0]                 portside_elevon,
	output logic signed [11:0]                 starboard_thrust,
	output logic signed [11:0]                 portside_thrust,
	output logic signed [11:0]                 gear_servo,
	output logic [6:0]                         transition_level,
	output logic [1:0]                         control_mode,
	output logic [1:0]                         airframe_mode,

	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [vtolmix_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [vtolmix_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [vtolmix_pkg::CFG_DATA_W-1:0] prdata,
	output logic                               pready
);

	vtolmix_pkg::cfg_t cfg;

	// Input register.
	logic               valid_s1;
	vtolmix_pkg::chan_t thro_s1;
	vtolmix_pkg::chan_t aile_s1;
	vtolmix_pkg::chan_t elev_s1;
	vtolmix_pkg::chan_t rudd_s1;
	vtolmix_pkg::chan_t csw_s1;
	vtolmix_pkg::chan_t gsw_s1;
	logic               rxf_s1;
	logic               imuf_s1;
	vtolmix_pkg::chan_t proll_s1;
	vtolmix_pkg::chan_t ppitch_s1;
	vtolmix_pkg::chan_t pyaw_s1;

	// Result register.
	logic                valid_s2;
	vtolmix_pkg::chan_t  re_s2;
	vtolmix_pkg::chan_t  le_s2;
	vtolmix_pkg::chan_t  rm_s2;
	vtolmix_pkg::chan_t  lm_s2;
	vtolmix_pkg::chan_t  gear_s2;
	vtolmix_pkg::level_t level_s2;
	vtolmix_pkg::cmode_t cmode_s2;
	vtolmix_pkg::fmode_t fmode_s2;

	// Combinational results of the single pass.
	vtolmix_pkg::mode_dec_t mode;
	vtolmix_pkg::chan_t     thro;
	vtolmix_pkg::chan_t     roll;
	vtolmix_pkg::chan_t     pitch;
	vtolmix_pkg::chan_t     yaw;
	vtolmix_pkg::level_t    level;
	logic                   horz;
	vtolmix_pkg::chan_t     gear;
	vtolmix_pkg::chan_t     re;
	vtolmix_pkg::chan_t     le;
	vtolmix_pkg::chan_t     rm;
	vtolmix_pkg::chan_t     lm;

	logic advance;
	logic in_take;

	// The request in the input register moves on whenever the result register is
	// empty or its content is being taken in this cycle.
	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	vtolmix_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			thro_s1   <= throttle_stick;
			aile_s1   <= aileron_stick;
			elev_s1   <= elevator_stick;
			rudd_s1   <= rudder_stick;
			csw_s1    <= control_switch;
			gsw_s1    <= gear_switch;
			rxf_s1    <= rx_failed;
			imuf_s1   <= imu_failed;
			proll_s1  <= roll_cmd;
			ppitch_s1 <= pitch_cmd;
			pyaw_s1   <= yaw_cmd;
		end
	end

	// Mode decode, stick forcing and the choice between stick and PID commands.
	vtolmix_mode u_mode (
		.cfg            (cfg),
		.throttle_stick (thro_s1),
		.aileron_stick  (aile_s1),
		.elevator_stick (elev_s1),
		.rudder_stick   (rudd_s1),
		.control_switch (csw_s1),
		.gear_switch    (gsw_s1),
		.rx_failed      (rxf_s1),
		.imu_failed     (imuf_s1),
		.roll_cmd       (proll_s1),
		.pitch_cmd      (ppitch_s1),
		.yaw_cmd        (pyaw_s1),
		.mode           (mode),
		.thro           (thro),
		.roll           (roll),
		.pitch          (pitch),
		.yaw            (yaw)
	);

	// Transition ramp; the level it reports already includes this request's step.
	vtolmix_trans u_trans (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.fmode   (mode.fmode),
		.level   (level),
		.horz    (horz),
		.gear    (gear)
	);

	vtolmix_mixer u_mixer (
		.cfg              (cfg),
		.horz             (horz),
		.thro             (thro),
		.roll             (roll),
		.pitch            (pitch),
		.yaw              (yaw),
		.starboard_elevon (re),
		.portside_elevon  (le),
		.starboard_thrust (rm),
		.portside_thrust  (lm)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			re_s2    <= re;
			le_s2    <= le;
			rm_s2    <= rm;
			lm_s2    <= lm;
			gear_s2  <= gear;
			level_s2 <= level;
			cmode_s2 <= mode.cmode;
			fmode_s2 <= mode.fmode;
		end
	end

	assign out_valid        = valid_s2;
	assign starboard_elevon = re_s2;
	assign portside_elevon  = le_s2;
	assign starboard_thrust = rm_s2;
	assign portside_thrust  = lm_s2;
	assign gear_servo       = gear_s2;
	assign transition_level = level_s2;
	assign control_mode     = cmode_s2;
	assign airframe_mode    = fmode_s2;

	// The ramp never leaves its range.
	a_level_range : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> transition_level <= vtolmix_pkg::MAX_TRANSITION)
		else $error("transition level above its maximum");

	// Below half transition the tilt servo sits at its minimum.
	a_gear_low : assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && transition_level < vtolmix_pkg::HALF_TRANSITION)
		|-> gear_servo == vtolmix_pkg::OUTPUT_MIN)
		else $error("gear servo moved below half transition");

	// A completed write to the margin register lands in the next cycle.
	a_cfg_write : assert property (@(posedge clk) disable iff (!arst_n)
		(arst_n && psel && penable && pwrite && pready &&
		 paddr[4:2] == vtolmix_pkg::REG_DEAD_MARGIN)
		|=> cfg.dead_margin == $past(pwdata[11:0]))
		else $error("dead-stick margin write lost");

endmodule
